>>> src/rc_stick_command_and_arming_unit_defines.svh
// Assertion macros shared by the stick command and arming unit.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef RC_STICK_COMMAND_AND_ARMING_UNIT_DEFINES_SVH
`define RC_STICK_COMMAND_AND_ARMING_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RCSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define RCSA_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);
`else
`define RCSA_ASSERT(lbl, prop, msg)
`define RCSA_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif
`endif

>>> src/rcsa_pkg.sv
// Types, constants and register codes of the stick command and arming unit.
// No dependencies; every module of the unit imports it.
package rcsa_pkg;

    localparam int CH_W        = 16;
    localparam int HOLD_W      = 8;
    localparam int ANGLE_W     = 23;
    localparam int ACC_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = 120;
    localparam int OUT_DATA_W  = 120;
    localparam int QUEUE_DEPTH = 2;

    // Reset values of the configuration registers
    localparam logic [CH_W-1:0]   RST_STICK_CENTER = 16'd1500;
    localparam logic [CH_W-1:0]   RST_STICK_HIGH   = 16'd1800;
    localparam logic [CH_W-1:0]   RST_STICK_LOW    = 16'd1200;
    localparam logic [CH_W-1:0]   RST_ARM_THR_LOW  = 16'd1100;
    localparam logic [CH_W-1:0]   RST_KILL_THR     = 16'd1150;
    localparam logic [HOLD_W-1:0] RST_HOLD_FRAMES  = 8'd5;

    // Switch codes
    localparam logic [CH_W-1:0] MODE_STAB_CODE = 16'd1000;
    localparam logic [CH_W-1:0] MODE_ALT_CODE  = 16'd1500;
    localparam logic [CH_W-1:0] DISARM_CODE    = 16'd1000;

    // Integrator steps and limits
    localparam logic signed [ACC_W:0]   YAW_STEP    = 33'sd2;
    localparam logic signed [ACC_W:0]   HEIGHT_STEP = 33'sd1;
    localparam logic signed [ACC_W-1:0] ACC_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN     = 32'sh8000_0000;

    // Angle scaling: |ch - center| * 256 / 25 through a reciprocal multiply
    localparam int           Q_FRAC_BITS = 8;
    localparam int           DIVISOR     = 25;
    localparam int           RECIP_W     = 28;
    localparam int           RECIP_SHIFT = 24;
    localparam int           QUOT_W      = 20;
    localparam logic [RECIP_W-1:0] RECIP_M = 28'd171798691; // floor(2^32 / 25)

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STICK_CENTER = 3'd0,
        CFG_STICK_HIGH   = 3'd1,
        CFG_STICK_LOW    = 3'd2,
        CFG_ARM_THR_LOW  = 3'd3,
        CFG_KILL_THR     = 3'd4,
        CFG_HOLD_FRAMES  = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_WAIT_LOW  = 3'd0,
        ST_WAIT_HIGH = 3'd1,
        ST_WAIT_LOW2 = 3'd2,
        ST_PREPARE   = 3'd3,
        ST_ARMED     = 3'd4,
        ST_EXIT      = 3'd5
    } t_arm_stage;

    typedef struct packed {
        logic [CH_W-1:0]   stick_center;
        logic [CH_W-1:0]   stick_high;
        logic [CH_W-1:0]   stick_low;
        logic [CH_W-1:0]   arm_thr_low;
        logic [CH_W-1:0]   kill_thr;
        logic [HOLD_W-1:0] hold_frames;
    } t_cfg;

    // One classified frame as it waits in the queue
    typedef struct packed {
        logic            ext_disarm;
        logic            yaw_hi;
        logic            yaw_lo;
        logic            thr_hi;
        logic            thr_lo;
        logic            thr_arm_lo;
        logic            kill;
        logic            mode_stab;
        logic            mode_alt;
        logic            disarm;
        logic            quick_arm;
        logic            roll_neg;
        logic [CH_W-1:0] roll_mag;
        logic            pitch_neg;
        logic [CH_W-1:0] pitch_mag;
    } t_item;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_sp;
        logic signed [ANGLE_W-1:0] pitch_sp;
        logic signed [ACC_W-1:0]   yaw_sp;
        logic signed [ACC_W-1:0]   height_sp;
        logic                      flight_mode;
        logic                      armed;
        logic                      alt_reset;
        t_arm_stage                stage;
    } t_result;

endpackage

>>> src/rc_stick_command_and_arming_unit.sv
// Path: an accepted frame goes from the queue through stage register r_a to the result register.
// Throughput: one frame per cycle without m_axis stalls; the back-end arming sequencer and
// integrators update once per frame; queue and result register absorb stalls on either side.
// Reset: i_rst_n low at a clock edge clears the queue, pipeline valids, sequencer, integrators
// and flags, and loads the configuration registers with their defaults.
// Top level: configuration registers, front end, frame queue and back end.
// Depends on rcsa_pkg, rcsa_front, rcsa_queue and rcsa_back.
module rc_stick_command_and_arming_unit #(
    parameter int QUEUE_DEPTH = rcsa_pkg::QUEUE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata from bit 0: roll_channel[15:0], pitch_channel[31:16], throttle_channel[47:32],
    // yaw_channel[63:48], mode_switch[79:64], disarm_switch[95:80], quick_arm[111:96],
    // outside_disarm[112], zero[119:113]
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [rcsa_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // tdata from bit 0: roll_setpoint[22:0], pitch_setpoint[45:23], yaw_setpoint[77:46],
    // height_setpoint[109:78], flight_mode_out[110], armed_out[111], altitude_reset[112],
    // arm_stage_out[115:113], zero[119:116]
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rcsa_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rcsa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rcsa_pkg::CH_W-1:0]            i_cfg_data
);
    import rcsa_pkg::*;

    t_cfg    r_cfg;
    t_item   w_front_item;
    t_item   w_q_item;
    t_result w_result;
    logic    w_room;
    logic    w_push;
    logic    w_q_valid;
    logic    w_q_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stick_center <= RST_STICK_CENTER;
            r_cfg.stick_high   <= RST_STICK_HIGH;
            r_cfg.stick_low    <= RST_STICK_LOW;
            r_cfg.arm_thr_low  <= RST_ARM_THR_LOW;
            r_cfg.kill_thr     <= RST_KILL_THR;
            r_cfg.hold_frames  <= RST_HOLD_FRAMES;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_STICK_CENTER: r_cfg.stick_center <= i_cfg_data;
                CFG_STICK_HIGH:   r_cfg.stick_high   <= i_cfg_data;
                CFG_STICK_LOW:    r_cfg.stick_low    <= i_cfg_data;
                CFG_ARM_THR_LOW:  r_cfg.arm_thr_low  <= i_cfg_data;
                CFG_KILL_THR:     r_cfg.kill_thr     <= i_cfg_data;
                CFG_HOLD_FRAMES:  r_cfg.hold_frames  <= i_cfg_data[HOLD_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    rcsa_front u_front (
        .i_tvalid (s_axis_tvalid),
        .i_tdata  (s_axis_tdata),
        .i_cfg    (r_cfg),
        .i_room   (w_room),
        .o_tready (s_axis_tready),
        .o_push   (w_push),
        .o_item   (w_front_item)
    );

    rcsa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_room  (w_room),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    rcsa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .o_q_ready     (w_q_ready),
        .i_q_item      (w_q_item),
        .i_hold_frames (r_cfg.hold_frames),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_result      (w_result)
    );

    assign m_axis_tdata = {4'b0000, w_result.stage, w_result.alt_reset, w_result.armed,
                           w_result.flight_mode, w_result.height_sp, w_result.yaw_sp,
                           w_result.pitch_sp, w_result.roll_sp};

endmodule

>>> src/rcsa_front.sv
// Front end: takes a frame off the input stream and classifies it.
// Depends on rcsa_pkg; feeds rcsa_queue.
module rcsa_front (
    input  logic                                 i_tvalid,
    input  logic [rcsa_pkg::IN_DATA_W-1:0]       i_tdata,
    input  rcsa_pkg::t_cfg                       i_cfg,
    input  logic                                 i_room,
    output logic                                 o_tready,
    output logic                                 o_push,
    output rcsa_pkg::t_item                      o_item
);
    import rcsa_pkg::*;

    logic [CH_W-1:0] w_roll;
    logic [CH_W-1:0] w_pitch;
    logic [CH_W-1:0] w_thr;
    logic [CH_W-1:0] w_yaw;
    logic [CH_W-1:0] w_aux1;
    logic [CH_W-1:0] w_aux2;
    logic [CH_W-1:0] w_aux6;

    assign w_roll  = i_tdata[15:0];
    assign w_pitch = i_tdata[31:16];
    assign w_thr   = i_tdata[47:32];
    assign w_yaw   = i_tdata[63:48];
    assign w_aux1  = i_tdata[79:64];
    assign w_aux2  = i_tdata[95:80];
    assign w_aux6  = i_tdata[111:96];

    assign o_tready = i_room;
    assign o_push   = i_tvalid && i_room;

    always_comb begin
        o_item.ext_disarm = i_tdata[112];
        o_item.yaw_hi     = w_yaw > i_cfg.stick_high;
        o_item.yaw_lo     = w_yaw < i_cfg.stick_low;
        o_item.thr_hi     = w_thr > i_cfg.stick_high;
        o_item.thr_lo     = w_thr < i_cfg.stick_low;
        o_item.thr_arm_lo = w_thr < i_cfg.arm_thr_low;
        o_item.kill       = (w_thr < i_cfg.kill_thr) && (w_yaw < i_cfg.stick_low);
        o_item.mode_stab  = w_aux1 == MODE_STAB_CODE;
        o_item.mode_alt   = w_aux1 == MODE_ALT_CODE;
        o_item.disarm     = w_aux2 == DISARM_CODE;
        o_item.quick_arm  = w_aux6 != '0;
        // split the roll and pitch offsets into sign and magnitude for the divider
        o_item.roll_neg   = w_roll < i_cfg.stick_center;
        o_item.roll_mag   = o_item.roll_neg ? (i_cfg.stick_center - w_roll)
                                            : (w_roll - i_cfg.stick_center);
        o_item.pitch_neg  = w_pitch < i_cfg.stick_center;
        o_item.pitch_mag  = o_item.pitch_neg ? (i_cfg.stick_center - w_pitch)
                                             : (w_pitch - i_cfg.stick_center);
    end

endmodule

>>> src/rcsa_queue.sv
// Short queue of classified frames between the front and back ends.
// Depends on rcsa_pkg and the assertion macro header.
`include "rc_stick_command_and_arming_unit_defines.svh"
module rcsa_queue #(
    parameter int DEPTH = rcsa_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rcsa_pkg::t_item i_item,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output rcsa_pkg::t_item o_item
);
    import rcsa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic [CNT_W-1:0]   n_count;
    logic               w_pop;

    assign o_room  = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `RCSA_ASSERT(a_q_no_overflow, i_push |-> (r_count < CNT_W'(DEPTH)), "push into full queue")
    `RCSA_ASSERT_NEXT(a_q_count_up, i_push && !w_pop, r_count == $past(r_count) + 1'b1, "count lost a push")
    `RCSA_ASSERT_NEXT(a_q_count_down, w_pop && !i_push, r_count == $past(r_count) - 1'b1, "count lost a pop")

endmodule

>>> src/rcsa_back.sv
// Back end: arming sequencer, integrators and angle scaling, then the result register.
// Depends on rcsa_pkg and the assertion macro header; fed by rcsa_queue.
`include "rc_stick_command_and_arming_unit_defines.svh"
module rcsa_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_ready,
    input  rcsa_pkg::t_item              i_q_item,
    input  logic [rcsa_pkg::HOLD_W-1:0]  i_hold_frames,
    output logic                         o_valid,
    input  logic                         i_ready,
    output rcsa_pkg::t_result            o_result
);
    import rcsa_pkg::*;

    localparam int PROD_W = CH_W + RECIP_W;
    localparam int NUM_W  = CH_W + Q_FRAC_BITS;

    typedef struct packed {
        logic                    roll_neg;
        logic [CH_W-1:0]         roll_mag;
        logic [QUOT_W-1:0]       roll_q0;
        logic                    pitch_neg;
        logic [CH_W-1:0]         pitch_mag;
        logic [QUOT_W-1:0]       pitch_q0;
        logic signed [ACC_W-1:0] yaw;
        logic signed [ACC_W-1:0] height;
        logic                    flight_mode;
        logic                    armed;
        logic                    alt_reset;
        t_arm_stage              stage;
    } t_stage_a;

    // Finish the division: one correction step, then apply the sign.
    function automatic logic signed [ANGLE_W-1:0] angle_fix(
        input logic              neg,
        input logic [CH_W-1:0]   mag,
        input logic [QUOT_W-1:0] q0
    );
        logic [NUM_W-1:0]   num;
        logic [NUM_W-1:0]   rem;
        logic [QUOT_W-1:0]  q;
        logic [ANGLE_W-1:0] qx;
        num = {mag, {Q_FRAC_BITS{1'b0}}};
        rem = num - NUM_W'(q0) * NUM_W'(DIVISOR);
        q   = (rem >= NUM_W'(DIVISOR)) ? q0 + 1'b1 : q0;
        qx  = ANGLE_W'(q);
        return neg ? -qx : qx;
    endfunction

    t_arm_stage              r_stage;
    t_arm_stage              n_stage;
    t_arm_stage              w_stage_eff;
    logic [HOLD_W-1:0]       r_cnt;
    logic [HOLD_W-1:0]       n_cnt;
    logic [HOLD_W-1:0]       w_cnt_inc;
    logic                    r_armed;
    logic                    n_armed;
    logic                    w_armed_pre;
    logic                    r_mode;
    logic                    n_mode;
    logic signed [ACC_W-1:0] r_yaw;
    logic signed [ACC_W-1:0] n_yaw;
    logic signed [ACC_W-1:0] r_height;
    logic signed [ACC_W-1:0] n_height;
    logic signed [ACC_W:0]   w_yaw_step;
    logic signed [ACC_W:0]   w_yaw_sum;
    logic signed [ACC_W:0]   w_height_step;
    logic signed [ACC_W:0]   w_height_sum;
    logic [PROD_W-1:0]       w_roll_prod;
    logic [PROD_W-1:0]       w_pitch_prod;
    t_stage_a                r_a;
    t_stage_a                n_a;
    logic                    r_a_valid;
    t_result                 r_out;
    t_result                 n_out;
    logic                    r_out_valid;
    logic                    w_out_ready;
    logic                    w_a_ready;
    logic                    w_pop;

    assign w_out_ready = !r_out_valid || i_ready;
    assign w_a_ready   = !r_a_valid || w_out_ready;
    assign w_pop       = i_q_valid && w_a_ready;
    assign o_q_ready   = w_a_ready;
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;

    // Integrators, saturating at the 32-bit limits
    always_comb begin
        w_yaw_step = '0;
        if (i_q_item.yaw_hi) begin
            w_yaw_step = -YAW_STEP;
        end else if (i_q_item.yaw_lo) begin
            w_yaw_step = YAW_STEP;
        end
        w_yaw_sum = {r_yaw[ACC_W-1], r_yaw} + w_yaw_step;
        if (w_yaw_sum[ACC_W] != w_yaw_sum[ACC_W-1]) begin
            n_yaw = w_yaw_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            n_yaw = w_yaw_sum[ACC_W-1:0];
        end

        w_height_step = '0;
        if (i_q_item.mode_alt && i_q_item.thr_hi) begin
            w_height_step = HEIGHT_STEP;
        end else if (i_q_item.mode_alt && i_q_item.thr_lo) begin
            w_height_step = -HEIGHT_STEP;
        end
        w_height_sum = {r_height[ACC_W-1], r_height} + w_height_step;
        if (w_height_sum[ACC_W] != w_height_sum[ACC_W-1]) begin
            n_height = w_height_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            n_height = w_height_sum[ACC_W-1:0];
        end
    end

    // Mode switch and the switch-driven arm flag, ahead of the sequencer
    always_comb begin
        n_mode = r_mode;
        if (i_q_item.mode_stab) begin
            n_mode = 1'b0;
        end else if (i_q_item.mode_alt) begin
            n_mode = 1'b1;
        end
        w_armed_pre = r_armed && !i_q_item.ext_disarm && !i_q_item.disarm;
        if (i_q_item.quick_arm && n_mode) begin
            w_armed_pre = 1'b1;
        end
    end

    // Kill sends the sequencer to exit, which runs in the same frame
    assign w_stage_eff = i_q_item.kill ? ST_EXIT : r_stage;
    assign w_cnt_inc   = r_cnt + 1'b1;

    // Arming sequencer: next stage
    always_comb begin
        n_stage = w_stage_eff;
        case (w_stage_eff)
            ST_WAIT_LOW: begin
                if (i_q_item.thr_arm_lo) n_stage = ST_WAIT_HIGH;
            end
            ST_WAIT_HIGH: begin
                if (i_q_item.thr_hi && (w_cnt_inc > i_hold_frames)) n_stage = ST_WAIT_LOW2;
            end
            ST_WAIT_LOW2: begin
                if (i_q_item.thr_arm_lo) n_stage = ST_PREPARE;
            end
            ST_PREPARE: begin
                n_stage = ST_ARMED;
            end
            ST_ARMED: begin
                if (!w_armed_pre) n_stage = ST_EXIT;
            end
            ST_EXIT: begin
                n_stage = ST_WAIT_LOW;
            end
            default: begin
                n_stage = ST_EXIT;
            end
        endcase
    end

    // Arming sequencer: flag and high-frame counter
    always_comb begin
        n_cnt   = r_cnt;
        n_armed = w_armed_pre;
        case (w_stage_eff)
            ST_WAIT_HIGH: begin
                if (i_q_item.thr_hi) begin
                    n_cnt = (w_cnt_inc > i_hold_frames) ? '0 : w_cnt_inc;
                end
            end
            ST_PREPARE: begin
                n_armed = 1'b1;
            end
            ST_EXIT: begin
                n_armed = 1'b0;
            end
            default: begin
                n_armed = w_armed_pre;
            end
        endcase
    end

    assign w_roll_prod  = PROD_W'(i_q_item.roll_mag) * PROD_W'(RECIP_M);
    assign w_pitch_prod = PROD_W'(i_q_item.pitch_mag) * PROD_W'(RECIP_M);

    always_comb begin
        n_a.roll_neg    = i_q_item.roll_neg;
        n_a.roll_mag    = i_q_item.roll_mag;
        n_a.roll_q0     = w_roll_prod[RECIP_SHIFT +: QUOT_W];
        n_a.pitch_neg   = i_q_item.pitch_neg;
        n_a.pitch_mag   = i_q_item.pitch_mag;
        n_a.pitch_q0    = w_pitch_prod[RECIP_SHIFT +: QUOT_W];
        n_a.yaw         = n_yaw;
        n_a.height      = n_height;
        n_a.flight_mode = n_mode;
        n_a.armed       = n_armed;
        n_a.alt_reset   = i_q_item.kill;
        n_a.stage       = n_stage;
    end

    always_comb begin
        n_out.roll_sp     = angle_fix(r_a.roll_neg, r_a.roll_mag, r_a.roll_q0);
        n_out.pitch_sp    = angle_fix(r_a.pitch_neg, r_a.pitch_mag, r_a.pitch_q0);
        n_out.yaw_sp      = r_a.yaw;
        n_out.height_sp   = r_a.height;
        n_out.flight_mode = r_a.flight_mode;
        n_out.armed       = r_a.armed;
        n_out.alt_reset   = r_a.alt_reset;
        n_out.stage       = r_a.stage;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_WAIT_LOW;
            r_cnt       <= '0;
            r_armed     <= 1'b0;
            r_mode      <= 1'b0;
            r_yaw       <= '0;
            r_height    <= '0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_stage  <= n_stage;
                r_cnt    <= n_cnt;
                r_armed  <= n_armed;
                r_mode   <= n_mode;
                r_yaw    <= n_yaw;
                r_height <= n_height;
            end
            if (w_a_ready) begin
                r_a_valid <= i_q_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_a <= n_a;
        end
        if (w_out_ready && r_a_valid) begin
            r_out <= n_out;
        end
    end

    `RCSA_ASSERT_NEXT(a_prepare_arms, w_pop && r_stage == ST_PREPARE && !i_q_item.kill, r_stage == ST_ARMED && r_armed, "prepare did not arm")
    `RCSA_ASSERT_NEXT(a_kill_disarms, w_pop && i_q_item.kill, r_stage == ST_WAIT_LOW && !r_armed, "kill left the unit armed")
    `RCSA_ASSERT(a_reset_pulse_disarmed, (r_out_valid && r_out.alt_reset) |-> !r_out.armed, "altitude reset while armed")

endmodule

>>> tb/sv/rcsa_cmd_checker.sv
`timescale 1ns / 1ps
// Checker for the stick command and arming unit: watches the frame, result and register
// channels, predicts every result and compares it field by field. Depends on rcsa_pkg.
module rcsa_cmd_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [rcsa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [rcsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [rcsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rcsa_pkg::CH_W-1:0]         i_cfg_data,
    output int                                o_pending,
    output int                                o_mismatches,
    output int                                o_checked
);
    import rcsa_pkg::*;

    t_cfg                    cfg;
    t_arm_stage              stage;
    logic [HOLD_W-1:0]       high_frames;
    logic                    armed;
    logic                    alt_mode;
    logic signed [ACC_W-1:0] yaw_acc;
    logic signed [ACC_W-1:0] height_acc;
    t_result                 cmd_q[$];
    int                      mismatches = 0;
    int                      checked = 0;

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
    endtask

    // (ch - center) * 256 / 25, truncated toward zero
    function automatic logic [ANGLE_W-1:0] angle_q8(input logic [CH_W-1:0] ch);
        longint diff;
        longint scaled;
        diff   = longint'({48'd0, ch}) - longint'({48'd0, cfg.stick_center});
        scaled = (diff * 256) / 25;
        return scaled[ANGLE_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_step(input logic signed [ACC_W-1:0] acc,
                                                        input int delta);
        longint sum;
        sum = longint'(acc) + delta;
        if (sum > longint'(ACC_MAX)) return ACC_MAX;
        if (sum < longint'(ACC_MIN)) return ACC_MIN;
        return sum[ACC_W-1:0];
    endfunction

    task automatic step_sticks(input logic [IN_DATA_W-1:0] d, output t_result r);
        logic [CH_W-1:0] roll, pitch, thr, yaw, aux1, aux2, aux6;
        logic            kill;
        roll  = d[15:0];
        pitch = d[31:16];
        thr   = d[47:32];
        yaw   = d[63:48];
        aux1  = d[79:64];
        aux2  = d[95:80];
        aux6  = d[111:96];
        kill  = 1'b0;

        if (d[112]) armed = 1'b0;

        if (yaw > cfg.stick_high) yaw_acc = sat_step(yaw_acc, -int'(YAW_STEP));
        else if (yaw < cfg.stick_low) yaw_acc = sat_step(yaw_acc, int'(YAW_STEP));

        if (aux1 == MODE_STAB_CODE) begin
            alt_mode = 1'b0;
        end else if (aux1 == MODE_ALT_CODE) begin
            alt_mode = 1'b1;
            if (thr > cfg.stick_high) height_acc = sat_step(height_acc, int'(HEIGHT_STEP));
            else if (thr < cfg.stick_low) height_acc = sat_step(height_acc, -int'(HEIGHT_STEP));
        end

        if (aux2 == DISARM_CODE) armed = 1'b0;
        if (aux6 != '0 && alt_mode) armed = 1'b1;

        // kill jumps to exit, which then runs in the same frame
        if (thr < cfg.kill_thr && yaw < cfg.stick_low) begin
            kill  = 1'b1;
            stage = ST_EXIT;
        end

        case (stage)
            ST_WAIT_LOW: begin
                if (thr < cfg.arm_thr_low) stage = ST_WAIT_HIGH;
            end
            ST_WAIT_HIGH: begin
                if (thr > cfg.stick_high) begin
                    high_frames = high_frames + 1'b1;
                    if (high_frames > cfg.hold_frames) begin
                        high_frames = '0;
                        stage       = ST_WAIT_LOW2;
                    end
                end
            end
            ST_WAIT_LOW2: begin
                if (thr < cfg.arm_thr_low) stage = ST_PREPARE;
            end
            ST_PREPARE: begin
                armed = 1'b1;
                stage = ST_ARMED;
            end
            ST_ARMED: begin
                if (!armed) stage = ST_EXIT;
            end
            ST_EXIT: begin
                armed = 1'b0;
                stage = ST_WAIT_LOW;
            end
            default: stage = ST_EXIT;
        endcase

        r.roll_sp     = angle_q8(roll);
        r.pitch_sp    = angle_q8(pitch);
        r.yaw_sp      = yaw_acc;
        r.height_sp   = height_acc;
        r.flight_mode = alt_mode;
        r.armed       = armed;
        r.alt_reset   = kill;
        r.stage       = stage;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            cfg = '{stick_center: RST_STICK_CENTER, stick_high: RST_STICK_HIGH,
                    stick_low: RST_STICK_LOW, arm_thr_low: RST_ARM_THR_LOW,
                    kill_thr: RST_KILL_THR, hold_frames: RST_HOLD_FRAMES};
            stage       = ST_WAIT_LOW;
            high_frames = '0;
            armed       = 1'b0;
            alt_mode    = 1'b0;
            yaw_acc     = '0;
            height_acc  = '0;
            cmd_q.delete();
        end else begin
            // compare before queuing, so a result can never match its own request
            if (m_axis_tvalid && m_axis_tready) begin
                got.roll_sp     = m_axis_tdata[22:0];
                got.pitch_sp    = m_axis_tdata[45:23];
                got.yaw_sp      = m_axis_tdata[77:46];
                got.height_sp   = m_axis_tdata[109:78];
                got.flight_mode = m_axis_tdata[110];
                got.armed       = m_axis_tdata[111];
                got.alt_reset   = m_axis_tdata[112];
                got.stage       = t_arm_stage'(m_axis_tdata[115:113]);
                if (cmd_q.size() == 0) begin
                    flag_mismatch("result with no request pending", 1, 0);
                end else begin
                    want = cmd_q.pop_front();
                    checked++;
                    if (got.roll_sp !== want.roll_sp)
                        flag_mismatch("roll_setpoint", got.roll_sp, want.roll_sp);
                    if (got.pitch_sp !== want.pitch_sp)
                        flag_mismatch("pitch_setpoint", got.pitch_sp, want.pitch_sp);
                    if (got.yaw_sp !== want.yaw_sp)
                        flag_mismatch("yaw_setpoint", got.yaw_sp, want.yaw_sp);
                    if (got.height_sp !== want.height_sp)
                        flag_mismatch("height_setpoint", got.height_sp, want.height_sp);
                    if (got.flight_mode !== want.flight_mode)
                        flag_mismatch("flight_mode_out", got.flight_mode, want.flight_mode);
                    if (got.armed !== want.armed)
                        flag_mismatch("armed_out", got.armed, want.armed);
                    if (got.alt_reset !== want.alt_reset)
                        flag_mismatch("altitude_reset", got.alt_reset, want.alt_reset);
                    if (got.stage !== want.stage)
                        flag_mismatch("arm_stage_out", got.stage, want.stage);
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STICK_CENTER: cfg.stick_center = i_cfg_data;
                    CFG_STICK_HIGH:   cfg.stick_high   = i_cfg_data;
                    CFG_STICK_LOW:    cfg.stick_low    = i_cfg_data;
                    CFG_ARM_THR_LOW:  cfg.arm_thr_low  = i_cfg_data;
                    CFG_KILL_THR:     cfg.kill_thr     = i_cfg_data;
                    CFG_HOLD_FRAMES:  cfg.hold_frames  = i_cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                step_sticks(s_axis_tdata, want);
                cmd_q.push_back(want);
            end
        end
        o_pending    <= cmd_q.size();
        o_mismatches <= mismatches;
        o_checked    <= checked;
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the stick command and arming testbench: clock, reset, frame and register stimulus,
// result stalls and the verdict. Depends on rcsa_pkg, the unit and rcsa_cmd_checker.
module tb_top;
    import rcsa_pkg::*;

    typedef struct {
        logic [CH_W-1:0] roll, pitch, thr, yaw, aux1, aux2, aux6;
        logic            ext;
    } t_frame;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CH_W-1:0]       i_cfg_data = '0;

    int   pending;
    int   mismatches;
    int   checked;
    t_cfg cur_cfg;
    bit   src_gaps = 1'b1;
    bit   sink_gaps = 1'b1;
    int   frames_sent = 0;
    int   settings_used = 0;

    rc_stick_command_and_arming_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    rcsa_cmd_checker cmd_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_mismatches  (mismatches),
        .o_checked     (checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stall bursts while sink_gaps is set
    initial begin
        forever begin
            @(posedge i_clk);
            if (sink_gaps && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    function automatic t_cfg default_cfg();
        return '{stick_center: RST_STICK_CENTER, stick_high: RST_STICK_HIGH,
                 stick_low: RST_STICK_LOW, arm_thr_low: RST_ARM_THR_LOW,
                 kill_thr: RST_KILL_THR, hold_frames: RST_HOLD_FRAMES};
    endfunction

    function automatic t_cfg random_cfg(input int hold);
        t_cfg c;
        c.stick_center = 16'($urandom_range(1000, 2000));
        c.stick_high   = c.stick_center + 16'($urandom_range(100, 500));
        c.stick_low    = c.stick_center - 16'($urandom_range(100, 500));
        c.arm_thr_low  = c.stick_low - 16'($urandom_range(0, 200));
        c.kill_thr     = c.stick_low - 16'($urandom_range(0, 100));
        c.hold_frames  = 8'(hold);
        return c;
    endfunction

    function automatic logic [CH_W-1:0] pick_below(input logic [CH_W-1:0] lim);
        if (lim == '0) return '0;
        if ($urandom_range(0, 1)) return lim - 16'($urandom_range(1, (lim < 16'd20) ? lim : 20));
        return 16'($urandom_range(0, int'(lim) - 1));
    endfunction

    function automatic logic [CH_W-1:0] pick_above(input logic [CH_W-1:0] lim);
        int room;
        room = 65535 - int'(lim);
        if (room == 0) return lim;
        if ($urandom_range(0, 1)) return lim + 16'($urandom_range(1, (room < 20) ? room : 20));
        return 16'($urandom_range(int'(lim) + 1, 65535));
    endfunction

    // between stick_low and stick_high: no integration, no kill; above stick_low if that range is empty
    function automatic logic [CH_W-1:0] pick_level();
        if (cur_cfg.stick_low <= cur_cfg.stick_high)
            return 16'($urandom_range(cur_cfg.stick_low, cur_cfg.stick_high));
        return pick_above(cur_cfg.stick_low);
    endfunction

    function automatic logic [CH_W-1:0] any_channel();
        logic [CH_W-1:0] lvl;
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'($urandom);
            3, 4: begin
                case ($urandom_range(0, 4))
                    0:       lvl = cur_cfg.stick_center;
                    1:       lvl = cur_cfg.stick_high;
                    2:       lvl = cur_cfg.stick_low;
                    3:       lvl = cur_cfg.arm_thr_low;
                    default: lvl = cur_cfg.kill_thr;
                endcase
                return lvl + 16'($urandom_range(0, 2)) - 16'd1;
            end
            default: return 16'($urandom_range(900, 2100));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] pick_mode();
        case ($urandom_range(0, 3))
            0:       return MODE_STAB_CODE;
            1:       return MODE_ALT_CODE;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_frame centered_frame();
        t_frame f;
        f.roll  = 16'd1500;
        f.pitch = 16'd1500;
        f.thr   = 16'd1500;
        f.yaw   = 16'd1500;
        f.aux1  = '0;
        f.aux2  = '0;
        f.aux6  = '0;
        f.ext   = 1'b0;
        return f;
    endfunction

    // random sticks that neither disarm nor kill
    function automatic t_frame calm_frame();
        t_frame f;
        f.roll  = any_channel();
        f.pitch = any_channel();
        f.thr   = pick_level();
        f.yaw   = pick_level();
        f.aux1  = pick_mode();
        f.aux2  = 16'($urandom_range(0, 2000));
        if (f.aux2 == DISARM_CODE) f.aux2 = '0;
        f.aux6  = '0;
        f.ext   = 1'b0;
        return f;
    endfunction

    function automatic t_frame noise_frame();
        t_frame f;
        f.roll  = any_channel();
        f.pitch = any_channel();
        f.thr   = any_channel();
        f.yaw   = any_channel();
        f.aux1  = pick_mode();
        f.aux2  = ($urandom_range(0, 7) == 0) ? DISARM_CODE : 16'($urandom);
        f.aux6  = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
        f.ext   = ($urandom_range(0, 9) == 0);
        return f;
    endfunction

    task automatic send_frame(input t_frame f);
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, f.ext, f.aux6, f.aux2, f.aux1, f.yaw, f.thr, f.pitch, f.roll};
        do @(posedge i_clk); while (!s_axis_tready);
        frames_sent++;
    endtask

    // hold the sender until every pending result is out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CH_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_regs(input t_cfg c);
        write_reg(CFG_STICK_CENTER, c.stick_center);
        write_reg(CFG_STICK_HIGH, c.stick_high);
        write_reg(CFG_STICK_LOW, c.stick_low);
        write_reg(CFG_ARM_THR_LOW, c.arm_thr_low);
        write_reg(CFG_KILL_THR, c.kill_thr);
        write_reg(CFG_HOLD_FRAMES, {8'd0, c.hold_frames});
        i_cfg_valid <= 1'b0;
        cur_cfg = c;
        settings_used++;
    endtask

    // low, high for more than hold_frames, low, armed a while, then disarm, kill or quick arm
    task automatic run_arm_sequence();
        t_frame f;
        int     n_hi;
        repeat ($urandom_range(1, 2)) begin
            f = calm_frame();
            f.thr = pick_below(cur_cfg.arm_thr_low);
            send_frame(f);
        end
        if (cur_cfg.stick_high == 16'hFFFF) n_hi = 3;
        else n_hi = int'(cur_cfg.hold_frames) + 1 + $urandom_range(0, 2);
        repeat (n_hi) begin
            f = calm_frame();
            // a stray level now and then does not count toward the high run
            if ($urandom_range(0, 9) != 0) f.thr = pick_above(cur_cfg.stick_high);
            send_frame(f);
        end
        f = calm_frame();
        f.thr = pick_below(cur_cfg.arm_thr_low);
        send_frame(f);
        repeat ($urandom_range(2, 6)) send_frame(calm_frame());
        f = calm_frame();
        case ($urandom_range(0, 3))
            0: f.aux2 = DISARM_CODE;
            1: f.ext = 1'b1;
            2: begin
                f.thr = pick_below(cur_cfg.kill_thr);
                f.yaw = pick_below(cur_cfg.stick_low);
            end
            default: begin
                f.aux1 = MODE_ALT_CODE;
                f.aux6 = 16'($urandom_range(1, 65535));
            end
        endcase
        send_frame(f);
        send_frame(calm_frame());
    endtask

    initial begin
        t_frame f;
        t_cfg   c;
        int     budget;
        int     start;
        cur_cfg = default_cfg();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // stick extremes and integrator directions under reset settings
        f = centered_frame();
        f.roll  = 16'd0;
        f.pitch = 16'hFFFF;
        send_frame(f);
        f = centered_frame();
        f.roll  = 16'hFFFF;
        f.pitch = 16'd0;
        f.yaw   = 16'hFFFF;
        send_frame(f);
        f = centered_frame();
        f.pitch = 16'd1499;
        f.yaw   = 16'd0;
        send_frame(f);
        f = centered_frame();
        f.aux1 = MODE_ALT_CODE;
        f.thr  = 16'hFFFF;
        send_frame(f);
        f.thr = 16'd1199;
        send_frame(f);
        // quick arm, switch disarm, rearm, outside disarm
        f.thr  = 16'd1500;
        f.aux6 = 16'd1;
        send_frame(f);
        f.aux6 = '0;
        f.aux2 = DISARM_CODE;
        send_frame(f);
        f.aux2 = '0;
        f.aux6 = 16'hFFFF;
        send_frame(f);
        f = centered_frame();
        f.ext  = 1'b1;
        f.aux1 = MODE_STAB_CODE;
        send_frame(f);
        f = centered_frame();
        f.aux1 = 16'd1234;
        f.aux6 = 16'd1;
        send_frame(f);
        // one full arming run ended by the kill
        f = centered_frame();
        f.thr = 16'd0;
        send_frame(f);
        f.thr = 16'd1801;
        repeat (6) send_frame(f);
        f.thr = 16'd1099;
        send_frame(f);
        f.thr = 16'd1500;
        repeat (3) send_frame(f);
        f.thr = 16'd1149;
        f.yaw = 16'd1199;
        send_frame(f);

        for (int p = 0; p < 6; p++) begin
            drain_results();
            case (p)
                0: c = default_cfg();
                1: c = '0;
                2: c = '1;
                3: begin
                    // hold of 255 can never be exceeded: the high count wraps
                    c = default_cfg();
                    c.stick_center = 16'hFFFF;
                    c.hold_frames  = 8'hFF;
                end
                4: c = random_cfg(0);
                default: c = random_cfg($urandom_range(1, 8));
            endcase
            program_regs(c);
            budget = (p == 3) ? 1 : (p == 1 || p == 2) ? 10 : 20;
            start  = frames_sent;
            while (frames_sent - start < budget) begin
                src_gaps  = (p != 5) && ($urandom_range(0, 3) != 0);
                sink_gaps = (p != 5) && ($urandom_range(0, 3) != 0);
                if (p == 3 || $urandom_range(0, 2) != 0) run_arm_sequence();
                else repeat ($urandom_range(3, 12)) send_frame(noise_frame());
                if (p != 5 && $urandom_range(0, 7) == 0) drain_results();
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("Ran %0d frames under %0d register settings, %0d results checked.",
                 frames_sent, settings_used, checked);
        $display("Stick extremes, mode and arm switches, kills, arming runs, hold count wrap.");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
